>>> hw/rtl/gc2c_pkg.sv
package gc2c_pkg;

   // coordinate widths: Q16.16 on the ports, exact headroom inside
   localparam int COORD_W   = 32;
   localparam int WIDE_W    = 36;
   localparam int ROW_OUT_W = 13;
   localparam int COL_OUT_W = 11;
   localparam int CSR_W     = 13;
   localparam int NUM_SEL   = 9;

   // result slots, in emission order for one item
   localparam int SEL_INNER = 0;
   localparam int SEL_LEFT  = 1;
   localparam int SEL_TOP   = 2;
   localparam int SEL_C00   = 3;
   localparam int SEL_BOT   = 4;
   localparam int SEL_CR0   = 5;
   localparam int SEL_RIGHT = 6;
   localparam int SEL_C0C   = 7;
   localparam int SEL_CRC   = 8;

   // register indexes
   localparam logic CSR_NUM_COLS = 1'b0;
   localparam logic CSR_NUM_ROWS = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;
   typedef wide_type [NUM_SEL-1:0]    corner_set_type;

   typedef struct packed {
      coord_type centre_x;
      coord_type centre_y;
   } req_payload_type;

   typedef struct packed {
      logic [ROW_OUT_W-1:0] corner_row;
      logic [COL_OUT_W-1:0] corner_col;
      coord_type            corner_x;
      coord_type            corner_y;
      logic                 last_of_run;
      logic                 grid_done;
   } rsp_payload_type;

   // per-item control that travels beside the arithmetic pipe
   typedef struct packed {
      logic [NUM_SEL-1:0]   mask;
      logic [ROW_OUT_W-1:0] row;
      logic [COL_OUT_W-1:0] col;
   } ctl_type;

endpackage

>>> hw/rtl/gc2c_interp.sv
module gc2c_interp
   import gc2c_pkg::*;
(
   input  logic           clock,
   input  logic           adv,
   input  coord_type      cur,
   input  coord_type      left,
   input  coord_type      up,
   input  coord_type      diag,
   output corner_set_type corners
);

   wide_type cur_w, left_w, up_w, diag_w, sum4;

   wide_type g2_ff, g2_in, sl_ff, sl_in, su_ff, su_in, sb_ff, sb_in, sr_ff, sr_in;
   wide_type g3_ff, lx_ff, lx_in, tx_ff, tx_in, bx_ff, bx_in, rx_ff, rx_in;
   corner_set_type corners_ff, corners_in;

   // sign-extend operands
   assign cur_w  = WIDE_W'(cur);
   assign left_w = WIDE_W'(left);
   assign up_w   = WIDE_W'(up);
   assign diag_w = WIDE_W'(diag);

   // stage 2: interior mean (floor) and the pair sums
   assign sum4  = cur_w + left_w + up_w + diag_w;
   assign g2_in = sum4 >>> 2;
   assign sl_in = left_w + diag_w;
   assign su_in = up_w + diag_w;
   assign sb_in = cur_w + left_w;
   assign sr_in = cur_w + up_w;

   // stage 3: edge extrapolation
   assign lx_in = sl_ff - g2_ff;
   assign tx_in = su_ff - g2_ff;
   assign bx_in = sb_ff - g2_ff;
   assign rx_in = sr_ff - g2_ff;

   // stage 4: grid corners from the adjoining edge values and the interior corner
   always_comb begin
      corners_in            = '0;
      corners_in[SEL_INNER] = g3_ff;
      corners_in[SEL_LEFT]  = lx_ff;
      corners_in[SEL_TOP]   = tx_ff;
      corners_in[SEL_C00]   = lx_ff + tx_ff - g3_ff;
      corners_in[SEL_BOT]   = bx_ff;
      corners_in[SEL_CR0]   = bx_ff + lx_ff - g3_ff;
      corners_in[SEL_RIGHT] = rx_ff;
      corners_in[SEL_C0C]   = tx_ff + rx_ff - g3_ff;
      corners_in[SEL_CRC]   = bx_ff + rx_ff - g3_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g2_ff      <= g2_in;
         sl_ff      <= sl_in;
         su_ff      <= su_in;
         sb_ff      <= sb_in;
         sr_ff      <= sr_in;
         g3_ff      <= g2_ff;
         lx_ff      <= lx_in;
         tx_ff      <= tx_in;
         bx_ff      <= bx_in;
         rx_ff      <= rx_in;
         corners_ff <= corners_in;
      end
   end

   assign corners = corners_ff;

endmodule

>>> hw/rtl/grid_centre_to_corner_top.sv
// Channel | Direction | Handshake                 | Payload
// req_    | in        | req_valid / req_stall     | req_payload_type (centre_x, centre_y)
// rsp_    | out       | rsp_valid / rsp_stall     | rsp_payload_type (corner row/col/x/y, marks)
// csr_    | in        | csr_we, csr_index         | csr_wdata (num_cols, num_rows)
//
// Items in row 0 or column 0 give no result. The single result port sets the
// pace: up to nine results for an item on the grid boundary, one per cycle while
// rsp_stall allows; req_ is held until the result stage sends an item's last result.
// Each item passes the first-stage operands, interp stages 2-4 and the output register.
// Synchronous reset clears control and counters; the line store is not cleared.
// rsp_stall freezes the whole pipe and stalls req_ once the result stage is busy.
module grid_centre_to_corner_top
   import gc2c_pkg::*;
#(
   parameter int MAX_COLS = 1024,
   parameter int MAX_ROWS = 4096
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_payload_type  req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_payload_type  rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int IDX_W     = $clog2(MAX_COLS);
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int CNT_COL_W = $clog2(MAX_COLS + 1);
   localparam int CNT_ROW_W = $clog2(MAX_ROWS + 1);

   // saturate the exact value to the 32-bit range
   function automatic coord_type sat_coord(input wide_type v);
      logic [WIDE_W-COORD_W:0] hi;
      hi = v[WIDE_W-1:COORD_W-1];
      if (hi == '0 || hi == '1) begin
         sat_coord = v[COORD_W-1:0];
      end else if (v[WIDE_W-1]) begin
         sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

   // configuration and position
   logic [CNT_COL_W-1:0] ncols_ff, ncols_in;
   logic [CNT_ROW_W-1:0] nrows_ff, nrows_in;
   logic [IDX_W-1:0]     col_ff;
   logic [ROW_W-1:0]     row_ff;
   logic [10:0]          cols_raw;
   logic                 col_end, row_end;

   // line store and first-stage operands
   logic [2*COORD_W-1:0] line_mem [MAX_COLS];
   logic [2*COORD_W-1:0] line_rd_ff;
   req_payload_type      cur1_ff, left1_ff, diag1_ff, up1;

   // pipe control
   ctl_type              ctl1_ff, ctl1_in, ctl2_ff, ctl3_ff, ctl4_ff;
   logic                 top_f, bot_f, lft_f, rgt_f, emit_f;
   logic                 req_accept, adv, go, last;
   logic [NUM_SEL-1:0]   onehot;
   corner_set_type       corners_x, corners_y;

   // result selection
   logic [ROW_OUT_W-1:0] row_opt [NUM_SEL];
   logic [COL_OUT_W-1:0] col_opt [NUM_SEL];
   rsp_payload_type      rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff;
   wide_type             x_sel, y_sel;

   // clamp register writes to the supported grid
   assign cols_raw = csr_wdata[10:0];
   always_comb begin
      if (cols_raw < 11'd2) begin
         ncols_in = CNT_COL_W'(2);
      end else if (32'(cols_raw) > MAX_COLS) begin
         ncols_in = CNT_COL_W'(MAX_COLS);
      end else begin
         ncols_in = CNT_COL_W'(cols_raw);
      end
      if (csr_wdata < 13'd2) begin
         nrows_in = CNT_ROW_W'(2);
      end else if (32'(csr_wdata) > MAX_ROWS) begin
         nrows_in = CNT_ROW_W'(MAX_ROWS);
      end else begin
         nrows_in = CNT_ROW_W'(csr_wdata);
      end
   end

   // handshake
   assign go         = (|ctl4_ff.mask) && (!rsp_valid_ff || !rsp_stall);
   assign onehot     = ctl4_ff.mask & (~ctl4_ff.mask + 1'b1);
   assign last       = (ctl4_ff.mask & ~onehot) == '0;
   assign adv        = (ctl4_ff.mask == '0) || (go && last);
   assign req_stall  = !adv;
   assign req_accept = req_valid && adv;

   // position flags of the incoming item
   assign col_end = CNT_COL_W'(col_ff) == ncols_ff - 1'b1;
   assign row_end = CNT_ROW_W'(row_ff) == nrows_ff - 1'b1;
   assign top_f   = row_ff == ROW_W'(1);
   assign bot_f   = row_end;
   assign lft_f   = col_ff == IDX_W'(1);
   assign rgt_f   = col_end;
   assign emit_f  = (row_ff != '0) && (col_ff != '0);

   always_comb begin
      ctl1_in = '0;
      if (req_accept && emit_f) begin
         ctl1_in.mask[SEL_INNER] = 1'b1;
         ctl1_in.mask[SEL_LEFT]  = lft_f;
         ctl1_in.mask[SEL_TOP]   = top_f;
         ctl1_in.mask[SEL_C00]   = top_f && lft_f;
         ctl1_in.mask[SEL_BOT]   = bot_f;
         ctl1_in.mask[SEL_CR0]   = bot_f && lft_f;
         ctl1_in.mask[SEL_RIGHT] = rgt_f;
         ctl1_in.mask[SEL_C0C]   = rgt_f && top_f;
         ctl1_in.mask[SEL_CRC]   = rgt_f && bot_f;
      end
      ctl1_in.row = ROW_OUT_W'(row_ff);
      ctl1_in.col = COL_OUT_W'(col_ff);
   end

   // configuration and position counters; a write restarts the grid
   always_ff @(posedge clock) begin
      if (reset) begin
         ncols_ff <= CNT_COL_W'(2);
         nrows_ff <= CNT_ROW_W'(2);
         col_ff   <= '0;
         row_ff   <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_NUM_COLS) begin
            ncols_ff <= ncols_in;
         end
         if (csr_index == CSR_NUM_ROWS) begin
            nrows_ff <= nrows_in;
         end
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         if (col_end) begin
            col_ff <= '0;
            row_ff <= row_end ? '0 : row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // line store: read the previous row's centre, write this one (read-first)
   always_ff @(posedge clock) begin
      if (req_accept) begin
         line_rd_ff      <= line_mem[col_ff];
         line_mem[col_ff] <= req_data;
      end
   end

   // first-stage operands: left and diagonal are the previous item's values
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cur1_ff  <= req_data;
         left1_ff <= cur1_ff;
         diag1_ff <= line_rd_ff;
      end
   end

   assign up1 = line_rd_ff;

   // control pipe, moving in step with the arithmetic
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else if (adv) begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
      end else if (go) begin
         ctl4_ff.mask <= ctl4_ff.mask & ~onehot;
      end
   end

   gc2c_interp u_interp_x (
      .clock   (clock),
      .adv     (adv),
      .cur     (cur1_ff.centre_x),
      .left    (left1_ff.centre_x),
      .up      (up1.centre_x),
      .diag    (diag1_ff.centre_x),
      .corners (corners_x)
   );

   gc2c_interp u_interp_y (
      .clock   (clock),
      .adv     (adv),
      .cur     (cur1_ff.centre_y),
      .left    (left1_ff.centre_y),
      .up      (up1.centre_y),
      .diag    (diag1_ff.centre_y),
      .corners (corners_y)
   );

   // corner position for each result slot
   always_comb begin
      row_opt[SEL_INNER] = ctl4_ff.row;
      row_opt[SEL_LEFT]  = ctl4_ff.row;
      row_opt[SEL_TOP]   = '0;
      row_opt[SEL_C00]   = '0;
      row_opt[SEL_BOT]   = ROW_OUT_W'(nrows_ff);
      row_opt[SEL_CR0]   = ROW_OUT_W'(nrows_ff);
      row_opt[SEL_RIGHT] = ctl4_ff.row;
      row_opt[SEL_C0C]   = '0;
      row_opt[SEL_CRC]   = ROW_OUT_W'(nrows_ff);
      col_opt[SEL_INNER] = ctl4_ff.col;
      col_opt[SEL_LEFT]  = '0;
      col_opt[SEL_TOP]   = ctl4_ff.col;
      col_opt[SEL_C00]   = '0;
      col_opt[SEL_BOT]   = ctl4_ff.col;
      col_opt[SEL_CR0]   = '0;
      col_opt[SEL_RIGHT] = COL_OUT_W'(ncols_ff);
      col_opt[SEL_C0C]   = COL_OUT_W'(ncols_ff);
      col_opt[SEL_CRC]   = COL_OUT_W'(ncols_ff);
   end

   // pick the lowest pending slot
   always_comb begin
      rsp_data_in = '0;
      x_sel       = '0;
      y_sel       = '0;
      for (int k = 0; k < NUM_SEL; k++) begin
         if (onehot[k]) begin
            x_sel                  = corners_x[k];
            y_sel                  = corners_y[k];
            rsp_data_in.corner_row = row_opt[k];
            rsp_data_in.corner_col = col_opt[k];
         end
      end
      rsp_data_in.corner_x    = sat_coord(x_sel);
      rsp_data_in.corner_y    = sat_coord(y_sel);
      rsp_data_in.last_of_run = last;
      rsp_data_in.grid_done   = onehot[SEL_CRC];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
